### rtl/core/signed_integer_to_radix_digits_defines.svh
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_defines.svh
// assertion macros for the signed integer to radix digits block
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define SITRD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sitrd: assertion failed");
// condition must never be seen at a clock edge out of reset
`define SITRD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sitrd: forbidden condition seen");
`else
`define SITRD_ASSERT(label, clk, rst_n, prop)
`define SITRD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

### rtl/core/sitrd_pkg.sv
// ----------------------------------------------------------------------------
// sitrd_pkg
// shared types, constants and helpers of the radix digit converter
// ----------------------------------------------------------------------------
package sitrd_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned CFG_W         = 64;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned BASE_W        = 5;
  localparam int unsigned ALPHA_SYMS    = 16;
  localparam int unsigned SYM_IDX_W     = 4;
  localparam int unsigned ALPHA_W       = ALPHA_SYMS * SYM_W;
  localparam int unsigned DEF_MAX_RADIX = 16;

  // quotient bits produced per division cycle
  localparam int unsigned BITS_PER_STEP = 8;
  localparam int unsigned DIV_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = $clog2(DIV_STEPS);

  // digit stack: radix 2 gives the longest text
  localparam int unsigned MAX_DIGITS    = VALUE_W;
  localparam int unsigned STK_IDX_W     = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W         = STK_IDX_W + 1;

  localparam logic [SYM_W-1:0] MINUS_SIGN = 8'h2D;
  localparam logic [SYM_W-1:0] PLUS_SIGN  = 8'h2B;
  localparam logic [SYM_W-1:0] NUL_SYM    = 8'h00;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE = 2'd2;

  typedef struct packed {
    logic load;
    logic chk_step;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic range_ok;
    logic neg;
    logic chk_bad;
    logic chk_done;
    logic quot_zero;
    logic at_digit_start;
    logic stack_empty;
    logic out_free;
    logic pop_last;
  } sts_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
                                               input logic [SYM_IDX_W-1:0] idx);
    return alpha[{idx, 3'b000} +: SYM_W];
  endfunction

endpackage

### rtl/core/sitrd_if.sv
// ----------------------------------------------------------------------------
// sitrd_if
// valid/ready channels for input values and output characters
// ----------------------------------------------------------------------------
interface sitrd_in_if import sitrd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitrd_out_if import sitrd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

### rtl/core/sitrd_ctrl.sv
// ----------------------------------------------------------------------------
// sitrd_ctrl
// sequencer: alphabet check, sign, digit division, digit output
// ----------------------------------------------------------------------------
module sitrd_ctrl import sitrd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_SIGN  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.range_ok) state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.chk_bad) begin
          state_d = ST_IDLE;
        end else if (sts_i.chk_done) begin
          state_d = sts_i.neg ? ST_SIGN : ST_DIV;
        end else begin
          cmd_o.chk_step = 1'b1;
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.at_digit_start && !sts_i.stack_empty && sts_i.quot_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.pop_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/sitrd_datapath.sv
// ----------------------------------------------------------------------------
// sitrd_datapath
// config registers, alphabet checker, digit divider, digit stack, output reg
// ----------------------------------------------------------------------------
module sitrd_datapath import sitrd_pkg::*; #(
  parameter int unsigned MAX_RADIX = DEF_MAX_RADIX
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [SYM_W-1:0]          out_symbol_o,
  output logic                      out_last_o
);

  localparam int unsigned DIG_W = $clog2(MAX_RADIX);
  localparam int unsigned REM_W = DIG_W + 1;

  logic [ALPHA_W-1:0]   alpha_q;
  logic [BASE_W-1:0]    base_q;
  logic [DIG_W-1:0]     chk_idx_q;
  logic [STEP_W-1:0]    step_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [VALUE_W-1:0]   dvd_q;
  logic [DIG_W-1:0]     rem_q;
  logic                 neg_q;
  logic [DIG_W-1:0]     digits_q [MAX_DIGITS];
  logic                 out_valid_q;
  logic [SYM_W-1:0]     out_symbol_q;
  logic                 out_last_q;

  logic [SYM_W-1:0]     chk_sym;
  logic                 chk_bad;
  logic [REM_W-1:0]     rt;
  logic [VALUE_W-1:0]   dt;
  logic [DIG_W-1:0]     rem_d;
  logic                 step_last;
  logic [CNT_W-1:0]     cnt_m1;
  logic [DIG_W-1:0]     top_digit;
  logic [VALUE_W-1:0]   raw;
  logic [VALUE_W-1:0]   mag;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALPHA_LO:  alpha_q[CFG_W-1:0]       <= cfg_data_i;
        REG_ALPHA_HI:  alpha_q[ALPHA_W-1:CFG_W] <= cfg_data_i;
        REG_BASE_SIZE: base_q                   <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // one symbol per cycle against the NUL and sign symbols and all later symbols in use
  assign chk_sym = sym_at(alpha_q, SYM_IDX_W'(chk_idx_q));

  always_comb begin
    chk_bad = (chk_sym == NUL_SYM) || (chk_sym == PLUS_SIGN) || (chk_sym == MINUS_SIGN);
    for (int j = 0; j < MAX_RADIX; j++) begin
      if (j > int'(chk_idx_q) && j < int'(base_q) &&
          sym_at(alpha_q, SYM_IDX_W'(j)) == chk_sym) begin
        chk_bad = 1'b1;
      end
    end
  end

  // restoring division, BITS_PER_STEP quotient bits a cycle
  always_comb begin
    rt = {1'b0, rem_q};
    dt = dvd_q;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      rt = {rt[DIG_W-1:0], dt[VALUE_W-1]};
      dt = {dt[VALUE_W-2:0], 1'b0};
      if (BASE_W'(rt) >= base_q) begin
        rt    = rt - REM_W'(base_q);
        dt[0] = 1'b1;
      end
    end
  end

  assign rem_d     = rt[DIG_W-1:0];
  assign step_last = (step_q == STEP_W'(DIV_STEPS - 1));
  assign cnt_m1    = cnt_q - CNT_W'(1);
  assign top_digit = digits_q[cnt_m1[STK_IDX_W-1:0]];
  assign raw       = value_i;
  assign mag       = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_idx_q <= '0;
      step_q    <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.load) begin
      chk_idx_q <= '0;
      step_q    <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.chk_step) chk_idx_q <= chk_idx_q + DIG_W'(1);
      if (cmd_i.div_step) begin
        step_q <= step_last ? '0 : step_q + STEP_W'(1);
        if (step_last) cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.emit_digit) begin
        cnt_q <= cnt_m1;
      end
    end
  end

  // dividend, remainder and digit stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvd_q <= mag;
      rem_q <= '0;
      neg_q <= raw[VALUE_W-1];
    end else if (cmd_i.div_step) begin
      dvd_q <= dt;
      rem_q <= step_last ? '0 : rem_d;
      if (step_last) digits_q[cnt_q[STK_IDX_W-1:0]] <= rem_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      out_symbol_q <= MINUS_SIGN;
      out_last_q   <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_symbol_q <= sym_at(alpha_q, SYM_IDX_W'(top_digit));
      out_last_q   <= (cnt_q == CNT_W'(1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_symbol_q;
  assign out_last_o   = out_last_q;

  always_comb begin
    sts_o                = '0;
    sts_o.range_ok       = (base_q >= BASE_W'(2)) && (base_q <= BASE_W'(MAX_RADIX));
    sts_o.neg            = neg_q;
    sts_o.chk_bad        = chk_bad;
    sts_o.chk_done       = (chk_idx_q == DIG_W'(base_q - BASE_W'(1)));
    sts_o.quot_zero      = (dvd_q == '0);
    sts_o.at_digit_start = (step_q == '0);
    sts_o.stack_empty    = (cnt_q == '0);
    sts_o.out_free       = !out_valid_q || out_ready_i;
    sts_o.pop_last       = (cnt_q == CNT_W'(1));
  end

endmodule

### rtl/core/signed_integer_to_radix_digits.sv
// each value runs the one-symbol-a-cycle alphabet check, then the sign if negative,
//   then the 8-bit-a-cycle digit divider before the first digit reaches the output
//   register; a new value is taken only once the previous one is through
// reset: alphabet and base size clear to zero, so values are dropped until configured
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// signed 32-bit value to text in a configured radix, one character per transfer
// ----------------------------------------------------------------------------
`include "signed_integer_to_radix_digits_defines.svh"

module signed_integer_to_radix_digits import sitrd_pkg::*; #(
  parameter int unsigned MAX_RADIX = DEF_MAX_RADIX
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // value in, characters out
  sitrd_in_if.sink             in_i,
  sitrd_out_if.source          out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // sequencer: idle, alphabet check, sign, divide, emit
  sitrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: digits are produced least significant first into a stack,
  // then popped most significant first through the output register
  sitrd_datapath #(
    .MAX_RADIX (MAX_RADIX)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .value_i      (in_i.value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_symbol_o (out_o.symbol),
    .out_last_o   (out_o.last)
  );

  // input is taken only between values
  assign in_i.ready = in_ready;

  // a base size in range moves the block out of idle right after the transfer
  `SITRD_ASSERT(a_busy_after_load, clk_i, rst_ni, (in_i.valid && in_i.ready && sts.range_ok) |=> !in_i.ready)
  // a character that is not the last one means the value is still in work
  `SITRD_ASSERT_NEVER(a_idle_mid_text, clk_i, rst_ni, out_o.valid && !out_o.last && in_i.ready)
  // digits are popped only from a filled stack
  `SITRD_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, cmd.emit_digit && sts.stack_empty)
  // the output register is written only when it is free
  `SITRD_ASSERT(a_emit_free, clk_i, rst_ni, (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)

endmodule
